// File: src/pmrm_pkg.sv
// Package for the pointer motion report merger: item types, slot entry layout,
// opcodes, register indexes and field widths. No dependencies.
`timescale 1ns / 1ps

package pmrm_pkg;

  localparam int DEF_MAX_DEVICES = 4;

  localparam int ACC_W     = 16;           // accumulator width
  localparam int MAG_W     = ACC_W + 1;    // magnitude of an accumulator
  localparam int THR_W     = 11;           // threshold register width
  localparam int BTN_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int REPORT_MAX = 127;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_MOTION = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_THRESHOLD = 2'd1;

  localparam logic KIND_ALLOC  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [1:0]              slot;
    logic signed [ACC_W-1:0] delta_x;
    logic signed [ACC_W-1:0] delta_y;
    logic signed [ACC_W-1:0] delta_wheel;
    logic [BTN_W-1:0]        button_bits;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [1:0]        assigned_slot;
    logic              alloc_failed;
    logic [BTN_W-1:0]  report_buttons;
    logic signed [7:0] report_x;
    logic signed [7:0] report_y;
    logic signed [7:0] report_wheel;
  } out_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] wheel;
    logic [BTN_W-1:0]        buttons;
  } slot_entry_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] quotient;
    logic [THR_W-1:0] remainder;
  } div_status_t;

endpackage

// File: src/pointer_motion_report_merger_core.sv
// Top level of the pointer motion report merger: slot memory, control sequencer
// and output register. Depends on pmrm_pkg and pmrm_div.
`timescale 1ns / 1ps

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  in      | in        | in_valid / in_stall  | in_data  (in_item_t)
//  out     | out       | out_valid / out_stall| out_data (out_item_t)
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//
// An allocate item passes through S_EMIT, a motion item through S_MOTION and an
// ignored item stays in S_IDLE; a report runs S_RWAIT and the 17-step divider
// in S_DIV for each slot (the three axes divide in parallel units). One item is
// worked on at a time; in_stall is high while an item is in progress. A
// finished result sits in the output register while the next item is accepted;
// a result is held back only when that register is still full. Reset clears
// the slot count, the thresholds (to 16) and the output register; slot memory
// is cleared entry by entry as slots are allocated, so no clearing pass is needed.

module pointer_motion_report_merger_core #(
  parameter int MAX_DEVICES = pmrm_pkg::DEF_MAX_DEVICES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pmrm_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output pmrm_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [pmrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmrm_pkg::THR_W-1:0]     cfg_data
);
  import pmrm_pkg::*;

  localparam int SLOT_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int CNT_W  = $clog2(MAX_DEVICES + 1);
  // Each step is at most 2^16 in magnitude; the sums must not wrap.
  localparam int SUM_W  = MAG_W + 1 + $clog2(MAX_DEVICES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOTION = 3'd1;
  localparam logic [2:0] S_RWAIT  = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;

  // Saturating 16-bit signed add.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_add = s[ACC_W-1:0];
    end
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [ACC_W-1:0] a);
    logic [MAG_W-1:0] e;
    e = {a[ACC_W-1], a};
    magnitude = a[ACC_W-1] ? (MAG_W'(0) - e) : e;
  endfunction

  function automatic logic signed [7:0] clamp_report(input logic signed [SUM_W-1:0] s);
    if (s > SUM_W'(REPORT_MAX)) begin
      clamp_report = 8'(REPORT_MAX);
    end else if (s < -SUM_W'(REPORT_MAX)) begin
      clamp_report = 8'(-REPORT_MAX);
    end else begin
      clamp_report = s[7:0];
    end
  endfunction

  function automatic logic signed [SUM_W-1:0] signed_step(input logic [MAG_W-1:0] q,
                                                          input logic neg);
    logic signed [SUM_W-1:0] e;
    e = SUM_W'(q);
    signed_step = neg ? -e : e;
  endfunction

  function automatic logic signed [ACC_W-1:0] signed_rem(input logic [THR_W-1:0] r,
                                                         input logic neg);
    logic signed [ACC_W-1:0] e;
    e = ACC_W'(r);
    signed_rem = neg ? -e : e;
  endfunction

  // Configuration registers.
  logic [THR_W-1:0] move_threshold;
  logic [THR_W-1:0] wheel_threshold;
  logic [THR_W-1:0] move_div;
  logic [THR_W-1:0] wheel_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold  <= THR_W'(16);
      wheel_threshold <= THR_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOVE_THRESHOLD:  move_threshold  <= cfg_data;
        REG_WHEEL_THRESHOLD: wheel_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // A threshold of zero divides by one.
  assign move_div  = (move_threshold == '0)  ? THR_W'(1) : move_threshold;
  assign wheel_div = (wheel_threshold == '0) ? THR_W'(1) : wheel_threshold;

  // Slot memory: one entry per device, read data registered.
  slot_entry_t mem [MAX_DEVICES];
  slot_entry_t mem_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_entry_t       mem_wdata;
  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Control state.
  logic [2:0]        state;
  logic [CNT_W-1:0]  slots_in_use;
  logic [SLOT_W-1:0] idx;
  in_item_t          item;
  out_item_t         res;
  logic              neg_x, neg_y, neg_w;
  logic [BTN_W-1:0]  btn_acc;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_w;

  logic accept;
  logic full;
  logic slot_ok;
  logic last_slot;
  logic out_free;
  logic div_start;
  div_status_t st_x, st_y, st_w;
  logic signed [SUM_W-1:0] step_x, step_y, step_w;
  slot_entry_t motion_entry;
  slot_entry_t div_entry;
  out_item_t   start_res;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign full      = (slots_in_use == CNT_W'(MAX_DEVICES));
  assign slot_ok   = ({{CNT_W{1'b0}}, in_data.slot} < {2'b00, slots_in_use});
  assign last_slot = ((CNT_W'(idx) + CNT_W'(1)) == slots_in_use);
  assign out_free  = !out_valid || !out_stall;
  assign div_start = (state == S_RWAIT);

  pmrm_div u_div_x (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(magnitude(mem_q.x)), .divisor(move_div), .status(st_x)
  );
  pmrm_div u_div_y (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(magnitude(mem_q.y)), .divisor(move_div), .status(st_y)
  );
  pmrm_div u_div_w (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(magnitude(mem_q.wheel)), .divisor(wheel_div), .status(st_w)
  );

  assign step_x = signed_step(st_x.quotient, neg_x);
  assign step_y = signed_step(st_y.quotient, neg_y);
  assign step_w = signed_step(st_w.quotient, neg_w);

  always_comb begin
    motion_entry.x       = sat_add(mem_q.x, item.delta_x);
    motion_entry.y       = sat_add(mem_q.y, item.delta_y);
    motion_entry.wheel   = sat_add(mem_q.wheel, item.delta_wheel);
    motion_entry.buttons = item.button_bits;

    div_entry.x       = signed_rem(st_x.remainder, neg_x);
    div_entry.y       = signed_rem(st_y.remainder, neg_y);
    div_entry.wheel   = signed_rem(st_w.remainder, neg_w);
    div_entry.buttons = mem_q.buttons;
  end

  // Result fields known when an item is accepted; a report fills in the rest
  // as it walks the slots.
  always_comb begin
    start_res              = '0;
    start_res.result_kind  = (in_data.opcode == OP_REPORT) ? KIND_REPORT : KIND_ALLOC;
    start_res.alloc_failed = (in_data.opcode == OP_ALLOC) && full;
    if (in_data.opcode == OP_ALLOC && !full) begin
      start_res.assigned_slot = 2'(slots_in_use);
    end
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && in_data.opcode == OP_ALLOC && !full) begin
          // A new slot starts with cleared accumulators and buttons.
          mem_we    = 1'b1;
          mem_waddr = slots_in_use[SLOT_W-1:0];
        end
        if (accept && in_data.opcode == OP_MOTION && slot_ok) begin
          mem_re    = 1'b1;
          mem_raddr = SLOT_W'(in_data.slot);
        end
        if (accept && in_data.opcode == OP_REPORT && slots_in_use != '0) begin
          mem_re = 1'b1;
        end
      end
      S_MOTION: begin
        mem_we    = 1'b1;
        mem_waddr = SLOT_W'(item.slot);
        mem_wdata = motion_entry;
      end
      S_DIV: begin
        if (st_x.done) begin
          mem_we    = 1'b1;
          mem_wdata = div_entry;
          if (!last_slot) begin
            mem_re    = 1'b1;
            mem_raddr = idx + SLOT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slots_in_use <= '0;
      out_valid    <= 1'b0;
    end else begin
      // S_EMIT refills the output register itself in the cycle it drains.
      if (out_valid && !out_stall && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_data;
            res  <= start_res;
            case (in_data.opcode)
              OP_ALLOC: begin
                if (!full) begin
                  slots_in_use <= slots_in_use + CNT_W'(1);
                end
                state <= S_EMIT;
              end
              OP_MOTION: begin
                if (slot_ok) begin
                  state <= S_MOTION;
                end
              end
              OP_REPORT: begin
                idx     <= '0;
                btn_acc <= '0;
                sum_x   <= '0;
                sum_y   <= '0;
                sum_w   <= '0;
                state   <= (slots_in_use == '0) ? S_EMIT : S_RWAIT;
              end
              default: ;
            endcase
          end
        end
        S_MOTION: begin
          state <= S_IDLE;
        end
        S_RWAIT: begin
          // Entry data is on mem_q now; the dividers start on its magnitudes.
          neg_x   <= mem_q.x[ACC_W-1];
          neg_y   <= mem_q.y[ACC_W-1];
          neg_w   <= mem_q.wheel[ACC_W-1];
          btn_acc <= btn_acc | mem_q.buttons;
          state   <= S_DIV;
        end
        S_DIV: begin
          if (st_x.done) begin
            if (last_slot) begin
              res.report_buttons <= btn_acc;
              res.report_x       <= clamp_report(sum_x + step_x);
              res.report_y       <= clamp_report(sum_y + step_y);
              res.report_wheel   <= clamp_report(sum_w + step_w);
              state              <= S_EMIT;
            end else begin
              sum_x <= sum_x + step_x;
              sum_y <= sum_y + step_y;
              sum_w <= sum_w + step_w;
              idx   <= idx + SLOT_W'(1);
              state <= S_RWAIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slots_in_use <= CNT_W'(MAX_DEVICES))
    else $error("slot count exceeds the number of devices");

  a_alloc_count: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.opcode == OP_ALLOC && !full)
      |=> slots_in_use == CNT_W'($past(slots_in_use) + CNT_W'(1)))
    else $error("allocation did not advance the slot count");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> CNT_W'(mem_waddr) <= slots_in_use)
    else $error("slot memory write beyond the allocated slots");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (st_x.done == st_y.done) && (st_y.done == st_w.done))
    else $error("axis dividers out of step");

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_valid && out_stall) |=> state == S_EMIT)
    else $error("result left the sequencer while the output register was full");
`endif

endmodule

// File: src/pmrm_div.sv
// Iterative restoring divider for accumulator magnitudes, one quotient bit per
// cycle. Depends on pmrm_pkg.
`timescale 1ns / 1ps

module pmrm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pmrm_pkg::MAG_W-1:0] dividend,
  input  logic [pmrm_pkg::THR_W-1:0] divisor,
  output pmrm_pkg::div_status_t     status
);
  import pmrm_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [THR_W-1:0] div;
  logic [THR_W-1:0] rem;
  logic [MAG_W-1:0] quo;
  logic             done;
  logic [THR_W:0]   trial;

  assign trial = {rem, quo[MAG_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(MAG_W);
      done <= 1'b0;
      div  <= divisor;
      rem  <= '0;
      quo  <= dividend;
    end else if (cnt != '0) begin
      cnt  <= cnt - CNT_W'(1);
      done <= (cnt == CNT_W'(1));
      if (trial >= {1'b0, div}) begin
        rem <= THR_W'(trial - {1'b0, div});
        quo <= {quo[MAG_W-2:0], 1'b1};
      end else begin
        rem <= trial[THR_W-1:0];
        quo <= {quo[MAG_W-2:0], 1'b0};
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign status.done      = done;
  assign status.quotient  = quo;
  assign status.remainder = rem;

endmodule

// File: test/pointer_motion_report_merger_core_tb.sv
// Self-checking testbench for pointer_motion_report_merger_core: a directed table, then
// random traffic under several threshold settings, checked against a built-in predictor.
// Depends on pmrm_pkg and the core RTL only.
`timescale 1ns / 1ps

module pointer_motion_report_merger_core_tb;
  import pmrm_pkg::*;

  localparam int NUM_SLOTS           = DEF_MAX_DEVICES;
  localparam int ITEMS_PER_SETTING   = 125;
  localparam int NUM_SETTINGS        = 6;
  localparam int CYCLE_LIMIT         = 400000;
  localparam int DRAIN_CYCLES        = 100;
  localparam int SETTLE_CYCLES       = 8;
  localparam int REPORTED_MISMATCHES = 10;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0]     cfg_data  = '0;

  // Shadow copy of the merger state, advanced once per accepted item.
  int unsigned      slots_used;
  int               acc_x     [NUM_SLOTS];
  int               acc_y     [NUM_SLOTS];
  int               acc_wheel [NUM_SLOTS];
  logic [BTN_W-1:0] held_buttons [NUM_SLOTS];
  logic [THR_W-1:0] move_thr;
  logic [THR_W-1:0] wheel_thr;

  out_item_t answers_due [$];
  out_item_t front_answer;
  dir_row_t  dir_rows [$];

  // When set, both sides run without idle cycles for a while.
  bit calm = 1'b0;

  int cycle_count  = 0;
  int fail_count   = 0;
  int results_seen = 0;
  int n_alloc      = 0;
  int n_motion     = 0;
  int n_report     = 0;
  int n_ignored    = 0;
  int n_settings   = 1;

  always #4 clk = ~clk;

  pointer_motion_report_merger_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int saturate_acc(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic signed [7:0] clamp_report(int v);
    if (v > REPORT_MAX) v = REPORT_MAX;
    else if (v < -REPORT_MAX) v = -REPORT_MAX;
    return v[7:0];
  endfunction

  // Whole steps leave the accumulator; the remainder keeps the sign of the
  // accumulator because division truncates toward zero. A zero threshold acts as 1.
  function automatic int take_steps(inout int acc, input logic [THR_W-1:0] thr);
    int divisor;
    int step;
    divisor = (thr == 0) ? 1 : int'(thr);
    step = acc / divisor;
    acc = acc - step * divisor;
    return step;
  endfunction

  // Advances the shadow state by one item and returns 1 when the item yields a result.
  function automatic bit compute_answer(input in_item_t it, output out_item_t ans);
    int               sum_x;
    int               sum_y;
    int               sum_w;
    int unsigned      i;
    logic [BTN_W-1:0] btn_or;
    ans = '0;
    sum_x = 0;
    sum_y = 0;
    sum_w = 0;
    btn_or = '0;
    case (it.opcode)
      OP_ALLOC: begin
        ans.result_kind = KIND_ALLOC;
        if (slots_used >= NUM_SLOTS) begin
          ans.alloc_failed = 1'b1;
        end else begin
          acc_x[slots_used] = 0;
          acc_y[slots_used] = 0;
          acc_wheel[slots_used] = 0;
          held_buttons[slots_used] = '0;
          ans.assigned_slot = slots_used[1:0];
          slots_used++;
        end
        return 1'b1;
      end
      OP_MOTION: begin
        // Motion to a slot that was never allocated is dropped silently.
        if (it.slot < slots_used) begin
          acc_x[it.slot] = saturate_acc(acc_x[it.slot] + int'(it.delta_x));
          acc_y[it.slot] = saturate_acc(acc_y[it.slot] + int'(it.delta_y));
          acc_wheel[it.slot] = saturate_acc(acc_wheel[it.slot] + int'(it.delta_wheel));
          held_buttons[it.slot] = it.button_bits;
        end
        return 1'b0;
      end
      OP_REPORT: begin
        for (i = 0; i < slots_used; i++) begin
          btn_or |= held_buttons[i];
          sum_x += take_steps(acc_x[i], move_thr);
          sum_y += take_steps(acc_y[i], move_thr);
          sum_w += take_steps(acc_wheel[i], wheel_thr);
        end
        // Sums are clamped only after all slots are added.
        ans.result_kind = KIND_REPORT;
        ans.report_buttons = btn_or;
        ans.report_x = clamp_report(sum_x);
        ans.report_y = clamp_report(sum_y);
        ans.report_wheel = clamp_report(sum_w);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic in_item_t mk_item(logic [1:0] op, logic [1:0] slot, int dx, int dy,
                                       int dw, logic [BTN_W-1:0] btn);
    in_item_t it;
    it.opcode = op;
    it.slot = slot;
    it.delta_x = ACC_W'(dx);
    it.delta_y = ACC_W'(dy);
    it.delta_wheel = ACC_W'(dw);
    it.button_bits = btn;
    return it;
  endfunction

  function automatic out_item_t alloc_answer(logic [1:0] slot, logic failed);
    out_item_t ans;
    ans = '0;
    ans.result_kind = KIND_ALLOC;
    ans.assigned_slot = slot;
    ans.alloc_failed = failed;
    return ans;
  endfunction

  function automatic dir_row_t drow(in_item_t it, bit typed, out_item_t want);
    dir_row_t r;
    r.item = it;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  // Mostly deltas a few thresholds wide, so that remainders and rounding toward
  // zero show up; the rest is full-range noise and the saturation extremes.
  function automatic logic signed [ACC_W-1:0] random_delta(input logic [THR_W-1:0] thr);
    int unsigned span;
    int unsigned pick;
    int          mag;
    span = (thr == 0) ? 1 : thr;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      mag = $urandom_range(0, 3 * span + 1);
      return ACC_W'(($urandom_range(0, 1) != 0) ? -mag : mag);
    end
    if (pick < 8) return ACC_W'($urandom());
    return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
  endfunction

  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) it.opcode = OP_ALLOC;
    else if (pick < 10) it.opcode = OP_UNUSED;
    else if (pick < 62) it.opcode = OP_MOTION;
    else it.opcode = OP_REPORT;
    it.slot = 2'($urandom_range(0, 3));
    it.delta_x = random_delta(move_thr);
    it.delta_y = random_delta(move_thr);
    it.delta_wheel = random_delta(wheel_thr);
    it.button_bits = BTN_W'($urandom_range(0, 255));
    return it;
  endfunction

  // Offers one item, waits for the handshake, then records what it should produce.
  // A typed row supplies its own expected result in place of the predicted one.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t ans;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (compute_answer(it, ans)) answers_due.push_back(typed ? want : ans);
    case (it.opcode)
      OP_ALLOC:  n_alloc++;
      OP_MOTION: n_motion++;
      OP_REPORT: n_report++;
      default:   n_ignored++;
    endcase
  endtask

  // Thresholds change only with the core idle: all results drained, and time
  // for a trailing motion item, which has no result, to finish.
  task automatic set_thresholds(input logic [THR_W-1:0] move_val,
                                input logic [THR_W-1:0] wheel_val);
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MOVE_THRESHOLD;
    cfg_data  <= move_val;
    @(posedge clk);
    cfg_index <= REG_WHEEL_THRESHOLD;
    cfg_data  <= wheel_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    move_thr = move_val;
    wheel_thr = wheel_val;
    n_settings++;
  endtask

  // Result side: a random number of stall cycles before each result.
  initial begin : result_sink
    int hold;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORTED_MISMATCHES)
          $display("cycle %0d: result with nothing expected: %p", cycle_count, out_data);
      end else begin
        front_answer = answers_due.pop_front();
        if (out_data !== front_answer) begin
          fail_count++;
          if (fail_count <= REPORTED_MISMATCHES)
            $display({"cycle %0d mismatch (expected/actual): kind %0b/%0b slot %0d/%0d ",
                      "failed %0b/%0b buttons %02h/%02h x %0d/%0d y %0d/%0d wheel %0d/%0d"},
                     cycle_count, front_answer.result_kind, out_data.result_kind,
                     front_answer.assigned_slot, out_data.assigned_slot,
                     front_answer.alloc_failed, out_data.alloc_failed,
                     front_answer.report_buttons, out_data.report_buttons,
                     front_answer.report_x, out_data.report_x,
                     front_answer.report_y, out_data.report_y,
                     front_answer.report_wheel, out_data.report_wheel);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, answers_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int               made;
    int unsigned      s;
    in_item_t         it;
    logic [THR_W-1:0] move_set  [NUM_SETTINGS];
    logic [THR_W-1:0] wheel_set [NUM_SETTINGS];

    slots_used = 0;
    for (s = 0; s < NUM_SLOTS; s++) begin
      acc_x[s] = 0;
      acc_y[s] = 0;
      acc_wheel[s] = 0;
      held_buttons[s] = '0;
    end
    move_thr = 11'd16;
    wheel_thr = 11'd16;

    // Extremes of the range, zero (taken as 1), all ones (beyond the nominal
    // range, used as it stands), one random pair and a last pair of 16 and 5.
    move_set  = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd0, 11'd16};
    wheel_set = '{11'd1, 11'd1024, 11'd2047, 11'd0, 11'd0, 11'd5};
    move_set[4]  = THR_W'($urandom_range(1, 1024));
    wheel_set[4] = THR_W'($urandom_range(1, 1024));

    // Directed part, run with the reset thresholds of 16.
    dir_rows.push_back(drow(mk_item(OP_REPORT, 2'd0, 0, 0, 0, 8'h00), 1'b1,
                            '{result_kind: KIND_REPORT, default: '0}));
    dir_rows.push_back(drow(mk_item(OP_MOTION, 2'd0, 100, -100, 50, 8'hFF), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_UNUSED, 2'd3, -1, -1, -1, 8'hFF), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_ALLOC, 2'd3, 0, 0, 0, 8'h00), 1'b1,
                            alloc_answer(2'd0, 1'b0)));
    dir_rows.push_back(drow(mk_item(OP_ALLOC, 2'd0, 0, 0, 0, 8'h00), 1'b1,
                            alloc_answer(2'd1, 1'b0)));
    dir_rows.push_back(drow(mk_item(OP_MOTION, 2'd2, 32767, 32767, 32767, 8'hFF), 1'b0, '0));
    // Saturation in both directions; opposite signs show that steps are summed
    // before the clamp.
    dir_rows.push_back(drow(mk_item(OP_MOTION, 2'd0, 32767, -32768, 32767, 8'h81), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_MOTION, 2'd0, 32767, -32768, 32767, 8'h81), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_MOTION, 2'd1, -32768, 32767, -32768, 8'h7E), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_MOTION, 2'd1, -32768, 32767, -32768, 8'h7E), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_REPORT, 2'd0, 0, 0, 0, 8'h00), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_ALLOC, 2'd1, 0, 0, 0, 8'h00), 1'b1,
                            alloc_answer(2'd2, 1'b0)));
    dir_rows.push_back(drow(mk_item(OP_ALLOC, 2'd2, 0, 0, 0, 8'h00), 1'b1,
                            alloc_answer(2'd3, 1'b0)));
    // Every slot taken: allocation fails and changes nothing.
    dir_rows.push_back(drow(mk_item(OP_ALLOC, 2'd0, 0, 0, 0, 8'h00), 1'b1,
                            alloc_answer(2'd0, 1'b1)));
    dir_rows.push_back(drow(mk_item(OP_ALLOC, 2'd3, -1, -1, -1, 8'hFF), 1'b1,
                            alloc_answer(2'd0, 1'b1)));
    // Large positive sums clamp at the upper limit.
    dir_rows.push_back(drow(mk_item(OP_MOTION, 2'd3, 32767, 32767, 32767, 8'h00), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_MOTION, 2'd2, 32767, 32767, 32767, 8'h10), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_MOTION, 2'd0, 32767, 32767, 32767, 8'h00), 1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_REPORT, 2'd3, 0, 0, 0, 8'h00), 1'b0, '0));
    // And large negative sums at the lower one.
    for (s = 0; s < NUM_SLOTS; s++)
      dir_rows.push_back(drow(mk_item(OP_MOTION, s[1:0], -32768, -32768, -32768, 8'h00),
                              1'b0, '0));
    dir_rows.push_back(drow(mk_item(OP_REPORT, 2'd1, 0, 0, 0, 8'h00), 1'b0, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // Random part: all slots are in use from here on, so extra allocations
    // keep exercising the failure answer.
    for (s = 0; s < NUM_SETTINGS; s++) begin
      set_thresholds(move_set[s], wheel_set[s]);
      made = 0;
      while (made < ITEMS_PER_SETTING) begin
        if (made % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        it = random_item();
        send_item(it, 1'b0, '0);
        if (it.opcode != OP_UNUSED) made++;
      end
    end

    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    fail_count += answers_due.size();

    $display("Run covered %0d allocations, %0d motion items, %0d reports and %0d ignored items",
             n_alloc, n_motion, n_report, n_ignored);
    $display("under %0d threshold settings; %0d results checked, %0d failures in %0d cycles",
             n_settings, results_seen, fail_count, cycle_count);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
